### rtl/time_tick_scaler_unit_defines.svh
// Assertion macros for the time tick scaler back end.
// No dependencies.
`ifndef TIME_TICK_SCALER_UNIT_DEFINES_SVH
`define TIME_TICK_SCALER_UNIT_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define TTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle outside reset.
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tts_pkg.sv
// Shared types and constants of the time tick scaler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;
  typedef enum logic [1:0] {
    CMD_NS_TO_TICKS = 2'd0,
    CMD_US_TO_TICKS = 2'd1,
    CMD_TICKS_TO_NS = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_EXACT = 2'd0,
    ST_SAT   = 2'd1,
    ST_ZDIV  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  localparam int unsigned FreqW = 40;
  localparam int unsigned ValW  = 64;
  localparam logic [FreqW-1:0] NsPerS = 40'd1000000000;
  localparam logic [FreqW-1:0] UsPerS = 40'd1000000;

  typedef struct packed {
    logic             fast;
    status_e          status;
    logic [ValW-1:0]  value;
    logic [FreqW-1:0] mul;
    logic [FreqW-1:0] div;
  } job_t;
endpackage
`default_nettype wire

### rtl/tts_front.sv
// Front end: accepts beats, picks multiplier and divisor, flags trivial cases.
// Depends on tts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tts_front import tts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [ValW-1:0]  value_i,
  input  wire logic [FreqW-1:0] freq_i,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i,
  output job_t                  job_o
);
  logic vld_q;
  job_t job_q, job_d;

  assign ready_o     = !vld_q || job_ready_i;
  assign job_valid_o = vld_q;
  assign job_o       = job_q;

  always_comb begin
    job_d.value  = value_i;
    job_d.mul    = freq_i;
    job_d.div    = NsPerS;
    job_d.fast   = 1'b0;
    job_d.status = ST_EXACT;
    unique case (cmd_e'(cmd_i))
      CMD_NS_TO_TICKS: job_d.div = NsPerS;
      CMD_US_TO_TICKS: job_d.div = UsPerS;
      CMD_TICKS_TO_NS: begin
        job_d.mul = NsPerS;
        job_d.div = freq_i;
        if (freq_i == '0) begin
          job_d.fast   = 1'b1;
          job_d.status = ST_ZDIV;
        end
      end
      default: job_d.fast = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      job_q <= job_d;
    end
  end
endmodule
`default_nettype wire

### rtl/tts_queue.sv
// Short queue between front and back ends.
// Depends on tts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tts_queue import tts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  job_t      in_job_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output job_t      out_job_o
);
  job_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_job_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_job_i;
  end
endmodule
`default_nettype wire

### rtl/tts_back.sv
// Back end: pipelined 64x40 multiply, saturation check, restoring divider.
// Depends on tts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "time_tick_scaler_unit_defines.svh"
module tts_back import tts_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  output logic                 job_ready_o,
  input  job_t                 job_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output logic [ValW-1:0]      result_o,
  output logic [1:0]           status_o
);
  localparam int unsigned NStg = ValW + 3;
  localparam int unsigned PW   = ValW + FreqW;
  localparam int unsigned HW   = ValW / 2 + FreqW;

  // stage register contents
  logic             v_q   [NStg];
  logic             f_q   [NStg];
  status_e          s_q   [NStg];
  logic [FreqW-1:0] d_q   [NStg];
  logic [PW-1:0]    r_q   [NStg];
  logic [ValW-1:0]  q_q   [NStg];
  logic [ValW-1:0]  lo_q  [NStg];
  logic [HW-1:0]    pa_q, pb_q;
  logic             adv;

  assign adv         = !v_q[NStg-1] || ready_i;
  assign job_ready_o = adv;
  assign valid_o     = v_q[NStg-1];
  assign result_o    = q_q[NStg-1];
  assign status_o    = s_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NStg; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= job_valid_i;
      for (int i = 1; i < NStg; i++) v_q[i] <= v_q[i-1];
    end
  end

  logic [PW-1:0]    prod;
  assign prod = {pa_q, 32'd0} + PW'(pb_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 0: two half products
      f_q[0] <= job_i.fast;
      s_q[0] <= job_i.status;
      d_q[0] <= job_i.div;
      pa_q   <= job_i.value[ValW-1:32] * job_i.mul;
      pb_q   <= job_i.value[31:0] * job_i.mul;
      // stage 1: sum and saturation check
      f_q[1] <= f_q[0];
      d_q[1] <= d_q[0];
      r_q[1] <= PW'(prod[PW-1:ValW]);
      lo_q[1] <= prod[ValW-1:0];
      q_q[1] <= '0;
      if (f_q[0]) begin
        s_q[1] <= s_q[0];
      end else if (prod[PW-1:ValW] >= d_q[0]) begin
        s_q[1] <= ST_SAT;
      end else begin
        s_q[1] <= ST_EXACT;
      end
      // stages 2..65: one quotient bit each
      for (int i = 2; i < NStg - 1; i++) begin
        f_q[i]  <= f_q[i-1];
        s_q[i]  <= s_q[i-1];
        d_q[i]  <= d_q[i-1];
        lo_q[i] <= {lo_q[i-1][ValW-2:0], 1'b0};
        if ({r_q[i-1][PW-2:0], lo_q[i-1][ValW-1]} >= {{(PW-FreqW){1'b0}}, d_q[i-1]}) begin
          r_q[i] <= {r_q[i-1][PW-2:0], lo_q[i-1][ValW-1]} - PW'(d_q[i-1]);
          q_q[i] <= {q_q[i-1][ValW-2:0], 1'b1};
        end else begin
          r_q[i] <= {r_q[i-1][PW-2:0], lo_q[i-1][ValW-1]};
          q_q[i] <= {q_q[i-1][ValW-2:0], 1'b0};
        end
      end
      // last stage: apply status
      s_q[NStg-1] <= s_q[NStg-2];
      if (f_q[NStg-2]) q_q[NStg-1] <= '0;
      else if (s_q[NStg-2] == ST_SAT) q_q[NStg-1] <= '1;
      else q_q[NStg-1] <= q_q[NStg-2];
    end
  end

  `TTS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, valid_o && !ready_i,
                   valid_o && $stable(result_o), "result changed under stall")
  `TTS_ASSERT_IMPL(a_sat_ones, clk_i, rst_ni, valid_o && status_o == ST_SAT,
                   result_o == '1, "saturated result not all ones")
  `TTS_ASSERT_IMPL(a_zdiv_zero, clk_i, rst_ni, valid_o && status_o == ST_ZDIV,
                   result_o == '0, "zero divisor result not zero")
  `TTS_ASSERT_IMPL(a_no_rsvd, clk_i, rst_ni, valid_o,
                   status_o != ST_RSVD, "reserved status")
endmodule
`default_nettype wire

### rtl/time_tick_scaler_unit.sv
// Channel  | dir | handshake            | payload
// cfg      | in  | cfg_valid/cfg_ready  | tsc_freq_hz (40b)
// in       | in  | in_valid/in_ready    | cmd (2b), value (64b)
// out      | out | out_valid/out_ready  | result (64b), status (2b)
// One item per cycle sustained while out_ready is high; the path is one front
// stage, the queue, two multiply stages, 64 divider stages and a fix-up stage.
// Reset clears all valid bits and the frequency register to zero.
// A stalled output halts the whole back-end pipeline; the queue then fills and stalls the front.
// Depends on tts_pkg, tts_front, tts_queue, tts_back.
`timescale 1ns / 1ps
`default_nettype none
module time_tick_scaler_unit import tts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [FreqW-1:0] tsc_freq_hz_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [ValW-1:0]  value_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ValW-1:0]       result_o,
  output logic [1:0]            status_o
);
  logic [FreqW-1:0] freq_q;
  logic f_vld, f_rdy, b_vld, b_rdy;
  job_t f_job, b_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= '0;
    end else if (cfg_valid_i) begin
      freq_q <= tsc_freq_hz_i;
    end
  end

  tts_front u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_o(in_ready_o), .cmd_i, .value_i,
    .freq_i(freq_q), .job_valid_o(f_vld), .job_ready_i(f_rdy), .job_o(f_job)
  );

  tts_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_vld), .in_ready_o(f_rdy), .in_job_i(f_job),
    .out_valid_o(b_vld), .out_ready_i(b_rdy), .out_job_o(b_job)
  );

  tts_back u_back (
    .clk_i, .rst_ni, .job_valid_i(b_vld), .job_ready_o(b_rdy), .job_i(b_job),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .result_o, .status_o
  );
endmodule
`default_nettype wire
